@@ src/kuz_pkg.sv @@
`timescale 1ns / 1ps
package kuz_pkg;
    typedef logic [7:0]   t_byte;
    typedef logic [127:0] t_blk;

    localparam int NUM_RK   = 10;
    localparam int KS_ROUNDS = 32;
    localparam int CFG_IDX_W = 2;
    localparam int KEY_W     = 64;

    localparam logic [1:0] CFG_KEY0 = 2'd0;
    localparam logic [1:0] CFG_KEY1 = 2'd1;
    localparam logic [1:0] CFG_KEY2 = 2'd2;
    localparam logic [1:0] CFG_KEY3 = 2'd3;

    typedef enum logic [2:0] {
        ST_EXPAND, ST_IDLE, ST_LOAD, ST_ENC, ST_DEC, ST_DONE
    } t_state;

    localparam logic [7:0] SBOX [256] = '{
     8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
     8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
     8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
     8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
     8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
     8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
     8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
     8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
     8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
     8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
     8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
     8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
     8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
     8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
     8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
     8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
    };

    localparam logic [7:0] LVEC [16] = '{
        8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1, 8'd251,
        8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148, 8'd1
    };

    // Multiply by a constant over GF(2^8), polynomial x^8+x^7+x^6+x+1.
    function automatic t_byte gf_mul(input t_byte a_in, input t_byte b_in);
        t_byte a;
        t_byte r;
        a = a_in;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (b_in[i]) r = r ^ a;
            a = a[7] ? ((a << 1) ^ 8'hC3) : (a << 1);
        end
        return r;
    endfunction

    function automatic t_byte sbox_inv(input t_byte v);
        t_byte r;
        r = '0;
        for (int i = 0; i < 256; i++) begin
            if (SBOX[i] == v) r = 8'(i);
        end
        return r;
    endfunction

    // Byte i of a block sits at bits [127-8i -: 8].
    function automatic t_byte get_b(input t_blk s, input int i);
        return s[127 - 8 * i -: 8];
    endfunction

    function automatic t_byte lin_comb(input t_blk s);
        t_byte t;
        t = '0;
        for (int i = 0; i < 16; i++) t = t ^ gf_mul(LVEC[i], get_b(s, i));
        return t;
    endfunction
endpackage

@@ src/kuz_if.sv @@
`timescale 1ns / 1ps
interface kuz_if #(
    parameter int W = 129
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/kuz_ram.sv @@
`timescale 1ns / 1ps
module kuz_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ src/kuz_round.sv @@
`timescale 1ns / 1ps
// One step of the shared round datapath. The linear map L is applied as
// sixteen shifts R, which lands sixteen byte-wide GF sums per stage; synthesis
// folds them into one xor network of constant multiplies.
module kuz_round (
    input  kuz_pkg::t_blk i_state,
    input  kuz_pkg::t_blk i_key,
    output kuz_pkg::t_blk o_fwd,
    output kuz_pkg::t_blk o_inv
);
    kuz_pkg::t_blk s_sub;
    kuz_pkg::t_blk s_fwd;
    kuz_pkg::t_blk s_lin;
    kuz_pkg::t_blk s_inv;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s_sub[127 - 8 * i -: 8] = kuz_pkg::SBOX[kuz_pkg::get_b(i_state ^ i_key, i)];
        end
        s_fwd = s_sub;
        for (int r = 0; r < 16; r++) begin
            s_fwd = {kuz_pkg::lin_comb(s_fwd), s_fwd[127:8]};
        end
        o_fwd = s_fwd;

        // The byte rotated to the end takes part in its own sum.
        s_lin = i_state;
        for (int r = 0; r < 16; r++) begin
            s_lin = {s_lin[119:0], s_lin[127:120]};
            s_lin[7:0] = kuz_pkg::lin_comb(s_lin);
        end
        for (int i = 0; i < 16; i++) begin
            s_inv[127 - 8 * i -: 8] = kuz_pkg::sbox_inv(kuz_pkg::get_b(s_lin, i));
        end
        o_inv = s_inv ^ i_key;
    end
endmodule

@@ src/gost_128bit_block_cipher_core.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Payload
// ------------------------------------------------------------
// cfg       in   index[1:0], data[63:0] (key words 0..3)
// in        in   {operation, block_high, block_low}  (129 bits)
// out       out  {result_high, result_low}           (128 bits)
//
// An item passes through a load state, ten round steps, each using a round key
// read from the key memory in the cycle before, and a state that presents the
// result. All round steps but one pass through the shared round unit; that
// one adds its key alone. The block then returns to idle for the next item.
// After the synchronous reset and after key writes, once the configuration
// channel goes quiet, the schedule runs 32 Feistel rounds and then stores the
// last key pair before the next item is taken. A result waits in the output
// register while the sink stalls; no item is taken until it has left.
module gost_128bit_block_cipher_core (
    input  logic i_clk,
    input  logic i_rst_n,
    kuz_if.sink   cfg,
    kuz_if.sink   in_ch,
    kuz_if.source out_ch
);
    // Round keys live in a 10 x 128 memory, one key per entry.
    logic       ram_we;
    logic [3:0] ram_waddr;
    logic [3:0] ram_raddr;
    kuz_pkg::t_blk ram_wdata;
    kuz_pkg::t_blk ram_rdata;

    kuz_ram #(.WIDTH(128), .DEPTH(kuz_pkg::NUM_RK)) u_keys (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    logic [kuz_pkg::KEY_W-1:0] r_key [4];
    kuz_pkg::t_state r_st, n_st;
    logic [5:0] r_cnt, n_cnt;
    kuz_pkg::t_blk r_a1, r_a0, r_s, r_c;
    logic r_op;
    logic r_stale;

    kuz_pkg::t_blk rnd_in, rnd_key, rnd_fwd, rnd_inv, cst;

    // Round constant C_(i+1) = L(i+1) built from the counter, so that it is
    // registered in the cycle before the round that uses it.
    always_comb begin
        cst = {120'h0, 2'b00, r_cnt + 6'd1};
        for (int r = 0; r < 16; r++) cst = {kuz_pkg::lin_comb(cst), cst[127:8]};
    end

    assign rnd_in  = (r_st == kuz_pkg::ST_EXPAND) ? r_a1 : r_s;
    assign rnd_key = (r_st == kuz_pkg::ST_EXPAND) ? r_c : ram_rdata;

    kuz_round u_round (.i_state(rnd_in), .i_key(rnd_key), .o_fwd(rnd_fwd), .o_inv(rnd_inv));

    assign cfg.ready    = (r_st == kuz_pkg::ST_IDLE);
    assign in_ch.ready  = (r_st == kuz_pkg::ST_IDLE) && !r_stale && !cfg.valid;
    assign out_ch.valid = (r_st == kuz_pkg::ST_DONE);
    assign out_ch.data  = r_s;

    // Next state.
    always_comb begin
        n_st  = r_st;
        n_cnt = r_cnt;
        case (r_st)
            kuz_pkg::ST_EXPAND: begin
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(kuz_pkg::KS_ROUNDS + 2)) n_st = kuz_pkg::ST_IDLE;
            end
            kuz_pkg::ST_IDLE: begin
                if (r_stale && !cfg.valid) begin
                    n_st  = kuz_pkg::ST_EXPAND;
                    n_cnt = 6'd1;
                end else if (in_ch.valid && in_ch.ready) begin
                    n_st  = kuz_pkg::ST_LOAD;
                    n_cnt = 6'd0;
                end
            end
            kuz_pkg::ST_LOAD: begin
                n_st  = r_op ? kuz_pkg::ST_DEC : kuz_pkg::ST_ENC;
                n_cnt = 6'd1;
            end
            kuz_pkg::ST_ENC, kuz_pkg::ST_DEC: begin
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(kuz_pkg::NUM_RK)) n_st = kuz_pkg::ST_DONE;
            end
            kuz_pkg::ST_DONE: if (out_ch.ready) n_st = kuz_pkg::ST_IDLE;
            default: n_st = kuz_pkg::ST_IDLE;
        endcase
    end

    // Memory control. Encryption reads keys 0..9, decryption 9..0; the
    // read is issued in the cycle before its use.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_a0;
        ram_raddr = '0;
        case (r_st)
            kuz_pkg::ST_EXPAND: begin
                // The pair left by round 8k passes through a0 in turn:
                // first its own a0, then its a1 after the next shift.
                if (r_cnt[2:0] == 3'd1) begin
                    ram_we = 1'b1; ram_waddr = 4'(r_cnt[5:2]) + 4'd1;
                end else if (r_cnt[2:0] == 3'd2) begin
                    ram_we = 1'b1; ram_waddr = 4'(r_cnt[5:2]);
                end
            end
            kuz_pkg::ST_LOAD: ram_raddr = r_op ? 4'd9 : 4'd0;
            kuz_pkg::ST_ENC:  ram_raddr = 4'(r_cnt[3:0]);
            kuz_pkg::ST_DEC:  ram_raddr = 4'd9 - 4'(r_cnt[3:0]);
            default: ram_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= kuz_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_stale <= 1'b1;
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
            if (cfg.valid && cfg.ready) begin
                r_stale <= 1'b1;
                case (cfg.data[65:64])
                    kuz_pkg::CFG_KEY0: r_key[0] <= cfg.data[63:0];
                    kuz_pkg::CFG_KEY1: r_key[1] <= cfg.data[63:0];
                    kuz_pkg::CFG_KEY2: r_key[2] <= cfg.data[63:0];
                    kuz_pkg::CFG_KEY3: r_key[3] <= cfg.data[63:0];
                    default: ;
                endcase
            end else if (r_st == kuz_pkg::ST_IDLE && r_stale) begin
                r_stale <= 1'b0;
            end
        end
    end

    function automatic kuz_pkg::t_blk cst_first();
        kuz_pkg::t_blk c;
        c = {120'h0, 8'd1};
        for (int r = 0; r < 16; r++) c = {kuz_pkg::lin_comb(c), c[127:8]};
        return c;
    endfunction

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_st)
            kuz_pkg::ST_IDLE: begin
                r_a1 <= {r_key[0], r_key[1]};
                r_a0 <= {r_key[2], r_key[3]};
                if (in_ch.valid && in_ch.ready) begin
                    r_op <= in_ch.data[128];
                    r_s  <= in_ch.data[127:0];
                end
            end
            kuz_pkg::ST_EXPAND: begin
                // The step after the last round still shifts a1 into a0 so
                // that the final pair can be stored.
                if (r_cnt != 6'd0 && r_cnt <= 6'(kuz_pkg::KS_ROUNDS + 1)) begin
                    r_a1 <= rnd_fwd ^ r_a0;
                    r_a0 <= r_a1;
                end
            end
            kuz_pkg::ST_ENC: begin
                if (r_cnt == 6'(kuz_pkg::NUM_RK)) r_s <= r_s ^ ram_rdata;
                else r_s <= rnd_fwd;
            end
            kuz_pkg::ST_DEC: begin
                if (r_cnt == 6'd1) r_s <= r_s ^ ram_rdata;
                else r_s <= rnd_inv;
            end
            default: r_s <= r_s;
        endcase
        r_c <= (r_st == kuz_pkg::ST_IDLE) ? cst_first() : cst;
    end
endmodule

@@ dv/kuz_test_if.sv @@
`timescale 1ns / 1ps
// The channel interface itself comes from src/kuz_if.sv; this file only holds
// the item types used by the checker.
package kuz_test_pkg;
    typedef struct packed {
        logic         decrypt;
        logic [63:0]  blk_hi;
        logic [63:0]  blk_lo;
    } t_block_item;

    typedef struct packed {
        logic [63:0] res_hi;
        logic [63:0] res_lo;
    } t_result_item;
endpackage

@@ dv/gost_128bit_block_cipher_core_checker.sv @@
`timescale 1ns / 1ps
module gost_128bit_block_cipher_core_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [65:0]  i_cfg_data,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [128:0] i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [127:0] i_out_data,
    output int           o_fail_count,
    output int           o_pending
);
    logic [63:0]                 key_words [4];
    kuz_pkg::t_blk               sched_keys [kuz_pkg::NUM_RK];
    kuz_test_pkg::t_result_item  expected_blocks [$];

    function automatic kuz_pkg::t_byte mul8(input kuz_pkg::t_byte a_in,
                                            input kuz_pkg::t_byte b);
        kuz_pkg::t_byte a;
        kuz_pkg::t_byte r;
        a = a_in;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= a;
            a = a[7] ? ((a << 1) ^ 8'hC3) : (a << 1);
        end
        return r;
    endfunction

    function automatic kuz_pkg::t_byte mix_byte(input kuz_pkg::t_blk s);
        kuz_pkg::t_byte t;
        t = '0;
        for (int i = 0; i < 16; i++) t ^= mul8(kuz_pkg::LVEC[i], s[127 - 8 * i -: 8]);
        return t;
    endfunction

    function automatic kuz_pkg::t_blk mix_fwd(input kuz_pkg::t_blk s_in);
        kuz_pkg::t_blk s;
        s = s_in;
        for (int r = 0; r < 16; r++) s = {mix_byte(s), s[127:8]};
        return s;
    endfunction

    function automatic kuz_pkg::t_blk mix_inv(input kuz_pkg::t_blk s_in);
        kuz_pkg::t_blk s;
        s = s_in;
        for (int r = 0; r < 16; r++) begin
            s = {s[119:0], s[127:120]};
            s[7:0] = mix_byte(s);
        end
        return s;
    endfunction

    function automatic kuz_pkg::t_blk subst(input kuz_pkg::t_blk s_in, input bit inverse);
        kuz_pkg::t_blk s;
        s = s_in;
        for (int i = 0; i < 16; i++) begin
            if (!inverse) s[8 * i +: 8] = kuz_pkg::SBOX[s[8 * i +: 8]];
            else begin
                for (int v = 0; v < 256; v++)
                    if (kuz_pkg::SBOX[v] == s_in[8 * i +: 8]) s[8 * i +: 8] = 8'(v);
            end
        end
        return s;
    endfunction

    // Rebuild the ten round keys from the current key words.
    function automatic void expand_schedule();
        kuz_pkg::t_blk a1;
        kuz_pkg::t_blk a0;
        kuz_pkg::t_blk t;
        a1 = {key_words[0], key_words[1]};
        a0 = {key_words[2], key_words[3]};
        sched_keys[0] = a1;
        sched_keys[1] = a0;
        for (int i = 1; i <= kuz_pkg::KS_ROUNDS; i++) begin
            t = mix_fwd(subst(a1 ^ mix_fwd(128'(i)), 1'b0)) ^ a0;
            a0 = a1;
            a1 = t;
            if ((i % 8) == 0) begin
                sched_keys[i / 4] = a1;
                sched_keys[i / 4 + 1] = a0;
            end
        end
    endfunction

    function automatic kuz_pkg::t_blk cipher_block(input kuz_test_pkg::t_block_item it);
        kuz_pkg::t_blk s;
        s = {it.blk_hi, it.blk_lo};
        if (!it.decrypt) begin
            for (int r = 0; r < kuz_pkg::NUM_RK - 1; r++)
                s = mix_fwd(subst(s ^ sched_keys[r], 1'b0));
            s ^= sched_keys[kuz_pkg::NUM_RK - 1];
        end else begin
            s ^= sched_keys[kuz_pkg::NUM_RK - 1];
            for (int r = kuz_pkg::NUM_RK - 2; r >= 0; r--)
                s = subst(mix_inv(s), 1'b1) ^ sched_keys[r];
        end
        return s;
    endfunction

    always @(posedge i_clk) begin
        kuz_test_pkg::t_result_item got;
        kuz_test_pkg::t_result_item want;
        kuz_pkg::t_blk              r;
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) key_words[k] = '0;
            expand_schedule();
            expected_blocks.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                key_words[i_cfg_data[65:64]] = i_cfg_data[63:0];
                expand_schedule();
            end
            if (i_in_valid && i_in_ready) begin
                r = cipher_block(kuz_test_pkg::t_block_item'(i_in_data));
                expected_blocks.push_back('{res_hi: r[127:64], res_lo: r[63:0]});
            end
            if (i_out_valid && i_out_ready) begin
                got = kuz_test_pkg::t_result_item'(i_out_data);
                if (expected_blocks.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_blocks.pop_front();
                    if (got.res_hi !== want.res_hi || got.res_lo !== want.res_lo) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %h_%h got %h_%h",
                                     want.res_hi, want.res_lo, got.res_hi, got.res_lo);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_blocks.size();
        end
    end
endmodule

@@ dv/gost_128bit_block_cipher_core_test.sv @@
`timescale 1ns / 1ps
module gost_128bit_block_cipher_core_test;
    localparam int STALL_LIMIT = 5000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   send_idle_pct;
    int   recv_idle_pct;

    kuz_if #(.W(66))  cfg ();
    kuz_if #(.W(129)) in_ch ();
    kuz_if #(.W(128)) out_ch ();

    gost_128bit_block_cipher_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch)
    );

    gost_128bit_block_cipher_core_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg.valid), .i_cfg_ready(cfg.ready), .i_cfg_data(cfg.data),
        .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready), .i_in_data(in_ch.data),
        .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready), .i_out_data(out_ch.data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // The receiver stalls at random at each falling edge, at the current rate.
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: any cycle without an accepted item counts toward the limit.
    always @(posedge i_clk) begin
        if ((cfg.valid && cfg.ready) || (in_ch.valid && in_ch.ready) ||
            (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Write one key word and hold valid until the block takes it. Valid stays
    // up on return so that the next word can follow at once; the caller drops it.
    task automatic write_key(input logic [1:0] idx, input logic [63:0] value);
        cfg.data  <= {idx, value};
        cfg.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg.ready);
        @(negedge i_clk);
    endtask

    task automatic load_key(input logic [255:0] key);
        write_key(kuz_pkg::CFG_KEY0, key[255:192]);
        write_key(kuz_pkg::CFG_KEY1, key[191:128]);
        write_key(kuz_pkg::CFG_KEY2, key[127:64]);
        write_key(kuz_pkg::CFG_KEY3, key[63:0]);
        cfg.valid <= 1'b0;
    endtask

    // Offer one block; the sender may idle a random number of cycles first.
    // Valid stays up on return; the next block or the drain decides its value.
    task automatic send_block(input logic decrypt, input logic [63:0] hi,
                              input logic [63:0] lo);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.data  <= {decrypt, hi, lo};
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Wait until every expected result has come back, then let the block settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_blocks(input int count);
        logic [63:0] hi;
        logic [63:0] lo;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(3))
                0: begin
                    hi = '0;
                    lo = 64'(1) << $urandom_range(63);
                end
                1: begin
                    hi = '1;
                    lo = ~rand64();
                end
                default: begin
                    hi = rand64();
                    lo = rand64();
                end
            endcase
            send_block(1'($urandom_range(1)), hi, lo);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        cfg.valid     = 1'b0;
        cfg.data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        out_ch.ready  = 1'b0;
        idle_cycles   = 0;
        send_idle_pct = 38;
        recv_idle_pct = 88;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed items under the all-zero reset key, then the standard key and the all-ones key.
        send_block(1'b0, '0, '0);
        send_block(1'b1, '0, '0);
        send_block(1'b0, '1, '1);
        send_block(1'b1, '1, '1);
        drain();
        load_key(256'h8899aabbccddeeff0011223344556677fedcba98765432100123456789abcdef);
        send_block(1'b0, 64'h1122334455667700, 64'hffeeddccbbaa9988);
        send_block(1'b1, 64'h7f679d90bebc2430, 64'h5a468d42b9d4edcd);
        send_block(1'b0, 64'h8000000000000000, 64'h0000000000000001);
        send_block(1'b1, 64'h0000000000000001, 64'h8000000000000000);
        drain();
        load_key('1);
        send_block(1'b0, '0, '1);
        send_block(1'b1, '1, '0);
        drain();
        // A single key word changed: the schedule must be rebuilt.
        write_key(kuz_pkg::CFG_KEY2, '0);
        cfg.valid <= 1'b0;
        send_block(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block(1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210);
        drain();

        // Random phases, each with a fresh random key; idling changes at phases 3 and 6.
        for (int phase = 0; phase < 9; phase++) begin
            if (phase == 3) begin
                send_idle_pct = 88;
                recv_idle_pct = 38;
            end else if (phase == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_key({rand64(), rand64(), rand64(), rand64()});
            random_blocks(100);
            drain();
        end

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
